// File: sv/smrbs_pkg.sv
package smrbs_pkg;

    localparam int unsigned COUNT_W    = 7;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned WORD_W     = 64;
    localparam int unsigned HALF_W     = WORD_W / 2;
    localparam int unsigned WORD_BYTES = WORD_W / BYTE_W;
    localparam int unsigned LANE_W     = $clog2(WORD_BYTES + 1);

    localparam logic [COUNT_W-1:0] MAX_BYTES = COUNT_W'(64);

    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [WORD_W-1:0] ROUND_MUL_A = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [WORD_W-1:0] ROUND_MUL_B = 64'h94D0_49BB_1331_11EB;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] operand;
    } mix_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mix_stat_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_stat_t;

    // Evaluated at elaboration only, to give the state after reset.
    function automatic logic [WORD_W-1:0] splitmix_step(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] t;
        t = v + GOLDEN_STEP;
        t = (t ^ (t >> 30)) * ROUND_MUL_A;
        t = (t ^ (t >> 27)) * ROUND_MUL_B;
        return t ^ (t >> 31);
    endfunction

    localparam logic [WORD_W-1:0] RESET_STATE = splitmix_step('0);

endpackage

// File: sv/splitmix_random_byte_source_top.sv
// A request leaves the queue; each 64-bit word of it is mixed, held in a buffer register,
// then loaded into the output register, which sends one byte per accepted transfer.
// Each word holds the shared 32x32 multiplier of the mixer while it runs; the next word
// is mixed once the buffer is free, while the output may still send the word before it.
// A seed write holds cfg_ready low while the mixer runs.
// Reset (aresetn low, synchronous) loads the state with the mixed zero seed.
module splitmix_random_byte_source_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [smrbs_pkg::COUNT_W-1:0]  s_byte_count,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [smrbs_pkg::WORD_W-1:0]   cfg_seed,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [smrbs_pkg::BYTE_W-1:0]   m_random_byte,
    output logic                           m_last_byte
);
    import smrbs_pkg::*;

    q_stat_t            q_stat;
    logic               q_push, q_pop;
    logic [COUNT_W-1:0] q_push_count, q_count;
    mix_ctl_t           mix_ctl;
    mix_stat_t          mix_stat;
    logic [WORD_W-1:0]  mix_result;

    smrbs_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_byte_count (s_byte_count),
        .q_stat       (q_stat),
        .q_push       (q_push),
        .q_push_count (q_push_count)
    );

    smrbs_queue u_queue (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_push       (q_push),
        .q_push_count (q_push_count),
        .q_pop        (q_pop),
        .q_stat       (q_stat),
        .q_count      (q_count)
    );

    smrbs_mixer u_mixer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .mix_ctl    (mix_ctl),
        .mix_stat   (mix_stat),
        .mix_result (mix_result)
    );

    smrbs_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_stat        (q_stat),
        .q_count       (q_count),
        .q_pop         (q_pop),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_seed      (cfg_seed),
        .mix_ctl       (mix_ctl),
        .mix_stat      (mix_stat),
        .mix_result    (mix_result),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_random_byte (m_random_byte),
        .m_last_byte   (m_last_byte)
    );

    a_cfg_blocks_next: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> !cfg_ready)
        else $error("seed write did not occupy the mixer");

    a_start_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mix_ctl.start |-> !mix_stat.busy && !mix_stat.done)
        else $error("mixer started while busy");

    a_queue_full_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.full |-> q_stat.valid)
        else $error("queue full but empty");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(mix_stat.done) |-> $past(mix_stat.busy))
        else $error("mixer result without a run");

endmodule

// File: sv/smrbs_front.sv
module smrbs_front (
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [smrbs_pkg::COUNT_W-1:0]  s_byte_count,
    input  smrbs_pkg::q_stat_t             q_stat,
    output logic                           q_push,
    output logic [smrbs_pkg::COUNT_W-1:0]  q_push_count
);
    import smrbs_pkg::*;

    logic count_zero;

    // Requests for no bytes are accepted and dropped; counts above MAX_BYTES saturate to it.
    assign count_zero   = (s_byte_count == '0);
    assign s_ready      = !q_stat.full;
    assign q_push       = s_valid && !q_stat.full && !count_zero;
    assign q_push_count = (s_byte_count > MAX_BYTES) ? MAX_BYTES : s_byte_count;

endmodule

// File: sv/smrbs_queue.sv
module smrbs_queue (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_push,
    input  logic [smrbs_pkg::COUNT_W-1:0]  q_push_count,
    input  logic                           q_pop,
    output smrbs_pkg::q_stat_t             q_stat,
    output logic [smrbs_pkg::COUNT_W-1:0]  q_count
);
    import smrbs_pkg::*;

    logic [COUNT_W-1:0] entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] fill_reg, fill_next;
    logic               do_push, do_pop;

    assign q_stat.valid = (fill_reg != '0);
    assign q_stat.full  = (fill_reg == Q_CNT_W'(Q_DEPTH));
    assign q_count      = entry_reg[rd_ptr_reg];

    assign do_push = q_push && !q_stat.full;
    assign do_pop  = q_pop && q_stat.valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= q_push_count;
        end
    end

endmodule

// File: sv/smrbs_mixer.sv
module smrbs_mixer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  smrbs_pkg::mix_ctl_t           mix_ctl,
    output smrbs_pkg::mix_stat_t          mix_stat,
    output logic [smrbs_pkg::WORD_W-1:0]  mix_result
);
    import smrbs_pkg::*;

    typedef enum logic [4:0] {
        MX_IDLE  = 5'b00001,
        MX_MUL0  = 5'b00010,
        MX_MUL1  = 5'b00100,
        MX_MUL2  = 5'b01000,
        MX_SHIFT = 5'b10000
    } mx_state_t;

    mx_state_t          state_reg, state_next;
    logic               round_reg, round_next;
    logic               done_reg, done_next;
    logic [WORD_W-1:0]  opnd_reg, acc_reg, result_reg;
    logic [WORD_W-1:0]  entry_sum, round_mul;
    logic [HALF_W-1:0]  mul_a, mul_b;
    logic [WORD_W-1:0]  product;

    assign entry_sum = mix_ctl.operand + GOLDEN_STEP;
    assign round_mul = round_reg ? ROUND_MUL_B : ROUND_MUL_A;

    // One 32x32 multiplier builds the low 64 bits of each product from three
    // partial products; the high-by-high term falls outside the kept bits.
    always_comb begin
        mul_a = opnd_reg[HALF_W-1:0];
        mul_b = round_mul[HALF_W-1:0];
        unique case (state_reg)
            MX_MUL1: mul_b = round_mul[WORD_W-1:HALF_W];
            MX_MUL2: mul_a = opnd_reg[WORD_W-1:HALF_W];
            default: ;
        endcase
    end

    assign product = WORD_W'(mul_a) * WORD_W'(mul_b);

    always_comb begin
        state_next = state_reg;
        round_next = round_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            MX_IDLE: begin
                if (mix_ctl.start) begin
                    state_next = MX_MUL0;
                    round_next = 1'b0;
                end
            end
            MX_MUL0:  state_next = MX_MUL1;
            MX_MUL1:  state_next = MX_MUL2;
            MX_MUL2:  state_next = MX_SHIFT;
            MX_SHIFT: begin
                if (!round_reg) begin
                    state_next = MX_MUL0;
                    round_next = 1'b1;
                end else begin
                    state_next = MX_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:  state_next = MX_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MX_IDLE;
            round_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            round_reg <= round_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            MX_IDLE: begin
                if (mix_ctl.start) begin
                    opnd_reg <= entry_sum ^ (entry_sum >> 30);
                end
            end
            MX_MUL0: acc_reg <= product;
            MX_MUL1, MX_MUL2: begin
                acc_reg[WORD_W-1:HALF_W] <= acc_reg[WORD_W-1:HALF_W] + product[HALF_W-1:0];
            end
            MX_SHIFT: begin
                if (!round_reg) begin
                    opnd_reg <= acc_reg ^ (acc_reg >> 27);
                end else begin
                    result_reg <= acc_reg ^ (acc_reg >> 31);
                end
            end
            default: ;
        endcase
    end

    assign mix_stat.busy = (state_reg != MX_IDLE);
    assign mix_stat.done = done_reg;
    assign mix_result    = result_reg;

endmodule

// File: sv/smrbs_back.sv
module smrbs_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  smrbs_pkg::q_stat_t             q_stat,
    input  logic [smrbs_pkg::COUNT_W-1:0]  q_count,
    output logic                           q_pop,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [smrbs_pkg::WORD_W-1:0]   cfg_seed,
    output smrbs_pkg::mix_ctl_t            mix_ctl,
    input  smrbs_pkg::mix_stat_t           mix_stat,
    input  logic [smrbs_pkg::WORD_W-1:0]   mix_result,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [smrbs_pkg::BYTE_W-1:0]   m_random_byte,
    output logic                           m_last_byte
);
    import smrbs_pkg::*;

    logic [WORD_W-1:0]  state_reg;
    logic [COUNT_W-1:0] req_left_reg;
    logic               seed_pend_reg;
    logic [LANE_W-1:0]  pend_cnt_reg;
    logic               pend_last_reg;
    logic               buf_valid_reg;
    logic [WORD_W-1:0]  buf_word_reg;
    logic [LANE_W-1:0]  buf_cnt_reg;
    logic               buf_last_reg;
    logic               em_valid_reg;
    logic [WORD_W-1:0]  em_word_reg;
    logic [LANE_W-1:0]  em_left_reg;
    logic               em_last_reg;

    logic               mix_idle, cfg_fire, word_start, word_done, seed_done;
    logic [LANE_W-1:0]  word_cnt;
    logic               word_last;
    logic               m_fire, em_end, em_load;

    assign mix_idle   = !mix_stat.busy && !mix_stat.done;
    assign cfg_ready  = mix_idle;
    assign cfg_fire   = cfg_valid && cfg_ready;
    assign word_start = mix_idle && !cfg_fire && (req_left_reg != '0) && !buf_valid_reg;
    assign word_done  = mix_stat.done && !seed_pend_reg;
    assign seed_done  = mix_stat.done && seed_pend_reg;

    assign word_last = (req_left_reg <= COUNT_W'(WORD_BYTES));
    assign word_cnt  = word_last ? req_left_reg[LANE_W-1:0] : LANE_W'(WORD_BYTES);

    assign mix_ctl.start   = cfg_fire || word_start;
    assign mix_ctl.operand = cfg_fire ? cfg_seed : state_reg;

    assign q_pop = q_stat.valid && (req_left_reg == '0);

    assign m_fire  = em_valid_reg && m_ready;
    assign em_end  = m_fire && (em_left_reg == LANE_W'(1));
    assign em_load = (!em_valid_reg || em_end) && buf_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= RESET_STATE;
            req_left_reg  <= '0;
            seed_pend_reg <= 1'b0;
            buf_valid_reg <= 1'b0;
            em_valid_reg  <= 1'b0;
        end else begin
            if (mix_stat.done) begin
                state_reg <= mix_result;
            end
            if (q_pop) begin
                req_left_reg <= q_count;
            end else if (word_start) begin
                req_left_reg <= req_left_reg - COUNT_W'(word_cnt);
            end
            if (cfg_fire) begin
                seed_pend_reg <= 1'b1;
            end else if (seed_done) begin
                seed_pend_reg <= 1'b0;
            end
            if (word_done) begin
                buf_valid_reg <= 1'b1;
            end else if (em_load) begin
                buf_valid_reg <= 1'b0;
            end
            if (em_load) begin
                em_valid_reg <= 1'b1;
            end else if (em_end) begin
                em_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (word_start) begin
            pend_cnt_reg  <= word_cnt;
            pend_last_reg <= word_last;
        end
        if (word_done) begin
            buf_word_reg <= mix_result;
            buf_cnt_reg  <= pend_cnt_reg;
            buf_last_reg <= pend_last_reg;
        end
        if (em_load) begin
            em_word_reg <= buf_word_reg;
            em_left_reg <= buf_cnt_reg;
            em_last_reg <= buf_last_reg;
        end else if (m_fire) begin
            em_word_reg <= em_word_reg >> BYTE_W;
            em_left_reg <= em_left_reg - 1'b1;
        end
    end

    assign m_valid       = em_valid_reg;
    assign m_random_byte = em_word_reg[BYTE_W-1:0];
    assign m_last_byte   = em_last_reg && (em_left_reg == LANE_W'(1));

endmodule

// File: tb/splitmix_random_byte_source_top_test.sv
`timescale 1ns / 1ps

module splitmix_random_byte_source_top_test;

    import smrbs_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned DRAIN_CYCLES  = 40;
    localparam int unsigned REPORT_LIMIT  = 10;

    typedef struct {
        logic [BYTE_W-1:0] value;
        logic              last;
    } byte_word_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [COUNT_W-1:0]  s_byte_count;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [WORD_W-1:0]   cfg_seed;
    logic                m_valid;
    logic                m_ready;
    logic [BYTE_W-1:0]   m_random_byte;
    logic                m_last_byte;

    byte_word_t          pending_bytes[$];
    logic [WORD_W-1:0]   generator_word;
    int unsigned         send_idle_pct;
    int unsigned         recv_idle_pct;
    int unsigned         mismatch_count;
    int unsigned         cycle_count;

    splitmix_random_byte_source_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_byte_count  (s_byte_count),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_seed      (cfg_seed),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_random_byte (m_random_byte),
        .m_last_byte   (m_last_byte)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [WORD_W-1:0] advance_generator(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] t;
        t = v + GOLDEN_STEP;
        t = (t ^ (t >> 30)) * ROUND_MUL_A;
        t = (t ^ (t >> 27)) * ROUND_MUL_B;
        return t ^ (t >> 31);
    endfunction

    function automatic void expect_request_bytes(input logic [COUNT_W-1:0] count);
        int unsigned total;
        int unsigned lane;
        byte_word_t  item;
        logic [WORD_W-1:0] word;
        total = 32'((count > MAX_BYTES) ? MAX_BYTES : count);
        word = '0;
        for (int unsigned i = 0; i < total; i++) begin
            lane = i % WORD_BYTES;
            if (lane == 0) begin
                generator_word = advance_generator(generator_word);
                word = generator_word;
            end
            item.value = word[lane*BYTE_W +: BYTE_W];
            item.last  = (i + 1 == total);
            pending_bytes.push_back(item);
        end
    endfunction

    function automatic logic [COUNT_W-1:0] pick_byte_count();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return '0;
        if (roll < 13)
            return COUNT_W'($urandom_range(127, 65));
        if (roll < 40)
            return COUNT_W'($urandom_range(16, 1));
        return COUNT_W'($urandom_range(64, 1));
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (aresetn)
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        byte_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_bytes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("ERROR: unexpected byte %02h last %0d",
                             m_random_byte, m_last_byte);
            end else begin
                want = pending_bytes.pop_front();
                if (m_random_byte !== want.value || m_last_byte !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("ERROR: byte expected %02h last %0d, got %02h last %0d",
                                 want.value, want.last, m_random_byte, m_last_byte);
                end
            end
        end
    end

    task automatic send_request(input logic [COUNT_W-1:0] count);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_byte_count <= count;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        expect_request_bytes(count);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_seed(input logic [WORD_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_seed  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        generator_word = advance_generator(value);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_reset();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        generator_word = advance_generator('0);
    endtask

    // The first requests after reset check the state loaded from the zero seed.
    task automatic test_reset_state();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_request(COUNT_W'(8));
        send_request(COUNT_W'(3));
        s_valid <= 1'b0;
    endtask

    task automatic test_count_limits();
        logic [COUNT_W-1:0] counts[$];
        counts = '{1, 7, 8, 9, 15, 16, 17, 63, 64, 0, 65, 127, 2, 0, 100, 24};
        send_idle_pct = 20;
        recv_idle_pct = 30;
        foreach (counts[i])
            send_request(counts[i]);
        s_valid <= 1'b0;
    endtask

    task automatic test_seed_writes();
        logic [WORD_W-1:0] seeds[$];
        seeds = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h1, {$urandom, $urandom}};
        send_idle_pct = 10;
        recv_idle_pct = 10;
        foreach (seeds[i]) begin
            write_seed(seeds[i]);
            send_request(COUNT_W'(9));
            send_request(COUNT_W'(64));
            s_valid <= 1'b0;
        end
    endtask

    task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                       input int unsigned requests,
                                       input logic [WORD_W-1:0] seed_value);
        write_seed(seed_value);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (requests)
            send_request(pick_byte_count());
        s_valid <= 1'b0;
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_byte_count   = '0;
        cfg_valid      = 1'b0;
        cfg_seed       = '0;
        m_ready        = 1'b0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        generator_word = '0;

        apply_reset();
        test_reset_state();
        test_count_limits();
        test_seed_writes();
        test_random_traffic(23, 66, 130, 64'hFFFF_FFFF_FFFF_FFFF);
        test_random_traffic(66, 23, 130, {$urandom, $urandom});
        test_random_traffic(0, 0, 130, 64'h0);

        wait_drained();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: splitmix_random_byte_source_top.f
sv/smrbs_pkg.sv
sv/smrbs_front.sv
sv/smrbs_queue.sv
sv/smrbs_mixer.sv
sv/smrbs_back.sv
sv/splitmix_random_byte_source_top.sv
tb/splitmix_random_byte_source_top_test.sv
